// ===== hdl/prtf_pkg.sv =====
package prtf_pkg;

  // Default table depth
  localparam int unsigned MaxRulesDef = 64;

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] port;
    logic        allow;
    logic        stateful;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       verdict;
    logic [6:0] rule_count;
  } out_item_t;

  // One stored rule
  typedef struct packed {
    logic [15:0] port;
    logic        allow;
    logic        stateful;
  } rule_t;

  // Operation token that walks the cell chain
  typedef struct packed {
    logic        vld;
    logic [1:0]  op;
    logic [15:0] port;
    logic        allow;
    logic        stateful;
    logic        found;
    logic        verdict;
  } tok_t;

endpackage

// ===== hdl/prtf_cell.sv =====
module prtf_cell
  import prtf_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] cnt_i,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  input  rule_t            nxt_rule_i,
  output rule_t            rule_o
);

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

  rule_t rule_q, rule_d;
  tok_t  tok_q, tok_d;
  logic  occ, hit_port;

  assign occ      = IdxC < cnt_i;
  assign hit_port = occ && (rule_q.port == tok_i.port);

  // Process the token passing this cell
  always_comb begin
    rule_d = rule_q;
    tok_d  = tok_i;
    if (tok_i.vld) begin
      case (tok_i.op)
        OP_ADD: begin
          // append at the first free slot
          if (IdxC == cnt_i) begin
            rule_d.port     = tok_i.port;
            rule_d.allow    = tok_i.allow;
            rule_d.stateful = tok_i.stateful;
          end
        end
        OP_REMOVE: begin
          // from the first port hit on, pull the next rule up one place
          if (tok_i.found || hit_port) begin
            rule_d      = nxt_rule_i;
            tok_d.found = 1'b1;
          end
        end
        OP_CHECK: begin
          if (!tok_i.found && hit_port && (rule_q.stateful == tok_i.stateful)) begin
            tok_d.found   = 1'b1;
            tok_d.verdict = rule_q.allow;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Clear the token under reset, else advance it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Advance rule contents
  always_ff @(posedge clk_i) begin
    rule_q <= rule_d;
  end

  assign tok_o  = tok_q;
  assign rule_o = rule_q;

endmodule

// ===== hdl/prtf_ctrl.sv =====
module prtf_ctrl
  import prtf_pkg::*;
#(
  parameter int unsigned MAX_RULES = MaxRulesDef,
  parameter int unsigned CNT_W     = $clog2(MaxRulesDef + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  output tok_t             tok_o,
  input  tok_t             tok_i,
  output logic [CNT_W-1:0] cnt_o
);

  localparam logic [CNT_W-1:0] MaxC = CNT_W'(MAX_RULES);
  localparam logic [CNT_W-1:0] OneC = CNT_W'(1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_vld_q, out_vld_d;
  logic             pend_vld_q, pend_vld_d;
  out_item_t        out_q, out_d, pend_q, pend_d, res;
  logic             accept, out_free, full;
  logic [CNT_W+6:0] cnt_ext;

  assign in_stall_o = busy_q || pend_vld_q;
  assign accept     = in_valid_i && !in_stall_o;

  // Launch the accepted item into the first cell
  always_comb begin
    tok_o          = '0;
    tok_o.vld      = accept;
    tok_o.op       = in_data_i.operation;
    tok_o.port     = in_data_i.port;
    tok_o.allow    = in_data_i.allow;
    tok_o.stateful = in_data_i.stateful;
  end

  // Form the result as the token leaves the last cell
  always_comb begin
    full           = (cnt_q == MaxC);
    cnt_d          = cnt_q;
    res.status     = ST_OK;
    res.verdict    = 1'b0;
    case (tok_i.op)
      OP_ADD: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          cnt_d = cnt_q + OneC;
        end
      end
      OP_REMOVE: begin
        if (tok_i.found) begin
          cnt_d = cnt_q - OneC;
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      OP_CHECK: begin
        res.verdict = tok_i.found ? tok_i.verdict : 1'b1;
      end
      default: begin
      end
    endcase
    if (!tok_i.vld) begin
      cnt_d = cnt_q;
    end
    cnt_ext        = {7'd0, cnt_d};
    res.rule_count = cnt_ext[6:0];
  end

  // Steer results into the output register or the pending slot
  always_comb begin
    out_free   = !out_vld_q || !out_stall_i;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    busy_d     = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (pend_vld_q && out_free) begin
      out_vld_d  = 1'b1;
      out_d      = pend_q;
      pend_vld_d = 1'b0;
    end else if (tok_i.vld) begin
      busy_d = 1'b0;
      if (out_free) begin
        out_vld_d = 1'b1;
        out_d     = res;
      end else begin
        pend_vld_d = 1'b1;
        pend_d     = res;
      end
    end else if (out_free) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign cnt_o       = cnt_q;

endmodule

// ===== hdl/port_rule_table_filter_unit.sv =====
// Channel   Direction  Signals                          Transfer when
// input     in         in_valid_i, in_stall_o, in_data_i   in_valid_i && !in_stall_o
// result    out        out_valid_o, out_stall_i, out_data_o out_valid_o && !out_stall_i
//
// One operation token walks the row of MAX_RULES rule cells, one cell per cycle,
// so its result is registered in the control block as it leaves the last cell;
// one item is in the row at a time, and the next is taken only once it has left.
// Reset empties the table at once through the rule count; no clearing pass.
// A result that meets a stalled output register parks in a pending slot;
// input stalls only while a token is in the row or that slot is full.
module port_rule_table_filter_unit
  import prtf_pkg::*;
#(
  parameter int unsigned MAX_RULES = MaxRulesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_RULES + 1);

  tok_t             tok_w  [MAX_RULES+1];
  rule_t            rule_w [MAX_RULES];
  logic [CntW-1:0]  cnt;

  prtf_ctrl #(
    .MAX_RULES (MAX_RULES),
    .CNT_W     (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .tok_o       (tok_w[0]),
    .tok_i       (tok_w[MAX_RULES]),
    .cnt_o       (cnt)
  );

  // Build the row of rule cells
  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    rule_t nxt;
    if (g == MAX_RULES - 1) begin : g_last
      assign nxt = rule_w[g];
    end else begin : g_mid
      assign nxt = rule_w[g+1];
    end
    prtf_cell #(
      .IDX   (g),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cnt_i      (cnt),
      .tok_i      (tok_w[g]),
      .tok_o      (tok_w[g+1]),
      .nxt_rule_i (nxt),
      .rule_o     (rule_w[g])
    );
  end

endmodule

// ===== hdl/prtf_checker.sv =====
module prtf_checker
  import prtf_pkg::*;
#(
  parameter int unsigned MAX_RULES = MaxRulesDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // One item in flight: stall right after each transfer
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // Full status only with a full table
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL) |->
      out_data_o.rule_count == 7'(MAX_RULES))
    else $error("full status with table not full");

  // An allow verdict comes only with ok status
  a_verdict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict |-> out_data_o.status == ST_OK)
    else $error("verdict set with error status");

endmodule

bind port_rule_table_filter_unit prtf_checker #(
  .MAX_RULES (MAX_RULES)
) u_prtf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
